### rtl/mbps_pkg.sv
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared constants and types for the masked byte pattern search core.
// ----------------------------------------------------------------------------
package mbps_pkg;

  // Window depth in bytes and width of the per-file offset counter
  localparam int MAX_PATTERN_BYTES = 16;
  localparam int OFFSET_BITS       = 48;

  localparam int PAT_BITS   = 8 * MAX_PATTERN_BYTES;
  localparam int LEN_BITS   = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int IDX_BITS   = $clog2(MAX_PATTERN_BYTES);
  localparam int FOUND_BITS = 31;

  // Configuration port: 64-bit registers at 8-byte strides
  localparam int DATA_BITS  = 64;
  localparam int ADDR_BITS  = 6;
  localparam int REG_LSB    = 3;
  localparam int RIDX_BITS  = ADDR_BITS - REG_LSB;

  // Register indexes
  localparam logic [RIDX_BITS-1:0] REG_PATTERN_LOW  = 3'd0;
  localparam logic [RIDX_BITS-1:0] REG_PATTERN_HIGH = 3'd1;
  localparam logic [RIDX_BITS-1:0] REG_MASK_LOW     = 3'd2;
  localparam logic [RIDX_BITS-1:0] REG_MASK_HIGH    = 3'd3;
  localparam logic [RIDX_BITS-1:0] REG_PATTERN_LEN  = 3'd4;
  localparam logic [RIDX_BITS-1:0] REG_MATCH_LIMIT  = 3'd5;

  // Settings seen by the datapath
  typedef struct packed {
    logic [PAT_BITS-1:0] pattern;
    logic [PAT_BITS-1:0] mask;
    logic [LEN_BITS-1:0] len_eff;   // pattern length clamped to 1..MAX
    logic                no_limit;  // match_limit negative
    logic [FOUND_BITS-1:0] limit;
  } mbps_cfg_t;

endpackage

### rtl/mbps_cell.sv
// ----------------------------------------------------------------------------
// mbps_cell
// One window byte: shifts toward the older end on each beat and compares
// the incoming byte, masked, against its selected pattern byte.
// ----------------------------------------------------------------------------
module mbps_cell (
  input  logic       clk,
  input  logic       rst,
  input  logic       shift,
  input  logic       clear,
  input  logic [7:0] din,
  input  logic [7:0] pat_byte,
  input  logic [7:0] mask_byte,
  input  logic       in_use,
  output logic [7:0] dout,
  output logic       hit
);

  logic [7:0] held;

  // Compare the value this cell takes on the current beat
  assign hit  = !in_use || ((din & mask_byte) == pat_byte);
  assign dout = held;

  // Window storage; end of file empties it after the byte is used
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 8'h00;
    end else if (shift) begin
      if (clear) begin
        held <= 8'h00;
      end else begin
        held <= din;
      end
    end
  end

endmodule

### rtl/mbps_cfg_regs.sv
// ----------------------------------------------------------------------------
// mbps_cfg_regs
// APB-style register file for pattern, mask, length and match limit.
// ----------------------------------------------------------------------------
module mbps_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mbps_pkg::ADDR_BITS-1:0] paddr,
  input  logic [mbps_pkg::DATA_BITS-1:0] pwdata,
  output logic [mbps_pkg::DATA_BITS-1:0] prdata,
  output logic                           pready,
  output mbps_pkg::mbps_cfg_t            cfg
);

  import mbps_pkg::*;

  logic [63:0] pattern_low;
  logic [63:0] pattern_high;
  logic [63:0] mask_low;
  logic [63:0] mask_high;
  logic [4:0]  pattern_len;
  logic [31:0] match_limit;

  logic                 wr_en;
  logic [RIDX_BITS-1:0] ridx;

  assign pready = 1'b1;
  assign ridx   = paddr[ADDR_BITS-1:REG_LSB];
  assign wr_en  = psel && penable && pwrite && pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low  <= '0;
      pattern_high <= '0;
      mask_low     <= '0;
      mask_high    <= '0;
      pattern_len  <= 5'd1;
      match_limit  <= '1;
    end else if (wr_en) begin
      unique case (ridx)
        REG_PATTERN_LOW:  pattern_low  <= pwdata;
        REG_PATTERN_HIGH: pattern_high <= pwdata;
        REG_MASK_LOW:     mask_low     <= pwdata;
        REG_MASK_HIGH:    mask_high    <= pwdata;
        REG_PATTERN_LEN:  pattern_len  <= pwdata[4:0];
        REG_MATCH_LIMIT:  match_limit  <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (ridx)
      REG_PATTERN_LOW:  prdata = pattern_low;
      REG_PATTERN_HIGH: prdata = pattern_high;
      REG_MASK_LOW:     prdata = mask_low;
      REG_MASK_HIGH:    prdata = mask_high;
      REG_PATTERN_LEN:  prdata = {59'd0, pattern_len};
      REG_MATCH_LIMIT:  prdata = {32'd0, match_limit};
      default:          prdata = '0;
    endcase
  end

  // Settings for the datapath; length clamped to 1..MAX_PATTERN_BYTES
  always_comb begin
    cfg.pattern  = {pattern_high, pattern_low};
    cfg.mask     = {mask_high, mask_low};
    cfg.no_limit = match_limit[31];
    cfg.limit    = match_limit[FOUND_BITS-1:0];
    if (pattern_len == 5'd0) begin
      cfg.len_eff = LEN_BITS'(1);
    end else if (pattern_len > 5'(MAX_PATTERN_BYTES)) begin
      cfg.len_eff = LEN_BITS'(MAX_PATTERN_BYTES);
    end else begin
      cfg.len_eff = LEN_BITS'(pattern_len);
    end
  end

endmodule

### rtl/masked_byte_pattern_search_core.sv
// ----------------------------------------------------------------------------
// masked_byte_pattern_search_core
// Streams file bytes through a row of window cells and reports the start
// offset of every masked pattern match.
// ----------------------------------------------------------------------------
// Takes one byte per cycle unless stalled. Each accepted byte enters a row of
// 16 window cells, and all cells compare their masked byte against the
// pattern in the same cycle; a match offset appears on the output register
// the cycle after the byte is taken. The single output register is the only
// buffer: input stalls only while a result sits there and the output side
// stalls. A byte flagged end_of_file may complete a match itself; the window
// and offset counter are cleared after it. The match count carries across
// files and stops results once a non-negative match_limit is reached.
module masked_byte_pattern_search_core (
  input  logic                             clk,
  input  logic                             rst,
  // input byte beats
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       data_byte,
  input  logic                             end_of_file,
  // result beats
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [mbps_pkg::OFFSET_BITS-1:0] match_offset,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mbps_pkg::ADDR_BITS-1:0]   paddr,
  input  logic [mbps_pkg::DATA_BITS-1:0]   pwdata,
  output logic [mbps_pkg::DATA_BITS-1:0]   prdata,
  output logic                             pready
);

  import mbps_pkg::*;

  mbps_cfg_t cfg;

  logic                   accept;
  logic [7:0]             cell_in  [MAX_PATTERN_BYTES];
  logic [7:0]             cell_out [MAX_PATTERN_BYTES];
  logic [MAX_PATTERN_BYTES-1:0] cell_hit;

  logic [OFFSET_BITS-1:0] file_count;
  logic [OFFSET_BITS-1:0] file_count_next;
  logic [FOUND_BITS-1:0]  found;
  logic                   limit_hit;
  logic                   enough;
  logic                   match;

  mbps_cfg_regs u_cfg (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  // Input is held only while a result waits and cannot leave
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // Window cells: cell 0 holds the newest byte; cell j lines up with
  // pattern byte len-1-j
  generate
    for (genvar j = 0; j < MAX_PATTERN_BYTES; j++) begin : g_cell
      logic [LEN_BITS-1:0] pidx;

      assign pidx = cfg.len_eff - LEN_BITS'(1) - LEN_BITS'(j);

      if (j == 0) begin : g_head
        assign cell_in[j] = data_byte;
      end else begin : g_body
        assign cell_in[j] = cell_out[j-1];
      end

      mbps_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift    (accept),
        .clear    (end_of_file),
        .din      (cell_in[j]),
        .pat_byte (cfg.pattern[8*pidx[IDX_BITS-1:0] +: 8]),
        .mask_byte(cfg.mask[8*pidx[IDX_BITS-1:0] +: 8]),
        .in_use   (LEN_BITS'(j) < cfg.len_eff),
        .dout     (cell_out[j]),
        .hit      (cell_hit[j])
      );
    end
  endgenerate

  // Saturating byte count including the current byte
  assign file_count_next = (file_count == '1) ? file_count : file_count + OFFSET_BITS'(1);
  assign enough    = file_count_next >= OFFSET_BITS'(cfg.len_eff);
  assign limit_hit = !cfg.no_limit && (found >= cfg.limit);
  assign match     = (&cell_hit) && enough && !limit_hit;

  // Per-file offset counter and persistent match count
  always_ff @(posedge clk) begin
    if (rst) begin
      file_count <= '0;
      found      <= '0;
    end else if (accept) begin
      if (end_of_file) begin
        file_count <= '0;
      end else begin
        file_count <= file_count_next;
      end
      if (match && (found != '1)) begin
        found <= found + FOUND_BITS'(1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= match;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      match_offset <= file_count_next - OFFSET_BITS'(cfg.len_eff);
    end
  end

endmodule

### tb/sv/tb_masked_byte_pattern_search_core.sv
// ----------------------------------------------------------------------------
// tb_masked_byte_pattern_search_core
// Self-checking bench for the masked byte pattern search core. Byte beats
// are predicted one by one against a local window model. Each reported
// offset is compared in order with the predicted ones. The search settings
// are reloaded over the register port between drained phases.
// ----------------------------------------------------------------------------
module tb_masked_byte_pattern_search_core;
  timeunit 1ns;
  timeprecision 1ps;

  import mbps_pkg::*;

  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_BYTES   = 165;

  typedef struct {
    logic [7:0] data;
    logic       eof;
  } byte_beat_t;

  // DUT connections, all inputs known from time zero
  logic                   clk;
  logic                   rst         = 1'b1;
  logic                   in_valid    = 1'b0;
  logic                   in_stall;
  logic [7:0]             data_byte   = 8'd0;
  logic                   end_of_file = 1'b0;
  logic                   out_valid;
  logic                   out_stall   = 1'b0;
  logic [OFFSET_BITS-1:0] match_offset;
  logic                   psel        = 1'b0;
  logic                   penable     = 1'b0;
  logic                   pwrite      = 1'b0;
  logic [ADDR_BITS-1:0]   paddr       = '0;
  logic [DATA_BITS-1:0]   pwdata      = '0;
  logic [DATA_BITS-1:0]   prdata;
  logic                   pready;

  // stimulus and expectations
  byte_beat_t             pending_bytes[$];
  byte_beat_t             next_beat;
  logic [OFFSET_BITS-1:0] expected_offsets[$];
  logic                   in_accepted = 1'b0;
  logic                   no_idle     = 1'b0;
  int                     hold_requests = 0;
  int                     holds_served  = 0;
  int                     hold_left     = 0;

  // shadow of the search settings
  logic [63:0]            pat_lo, pat_hi, msk_lo, msk_hi;
  logic [4:0]             len_raw;
  logic [31:0]            limit_raw;

  // search state
  logic [7:0]             recent_bytes[MAX_PATTERN_BYTES];
  logic [OFFSET_BITS-1:0] file_count;
  logic [30:0]            found_count;

  // run statistics
  int                     mismatch_count  = 0;
  int                     bytes_taken     = 0;
  int                     offsets_checked = 0;
  int                     files_closed    = 0;
  int                     settings_loaded = 0;

  masked_byte_pattern_search_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .end_of_file  (end_of_file),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .match_offset (match_offset),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic note_failure(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", what);
  endtask

  // pattern length clamped to 1..16
  function automatic int active_len();
    if (len_raw == 0) return 1;
    if (len_raw > MAX_PATTERN_BYTES) return MAX_PATTERN_BYTES;
    return int'(len_raw);
  endfunction

  // shift one byte into the window and predict its match offset, if any
  task automatic scan_byte(input logic [7:0] b, input logic eof);
    int          len;
    logic        hit;
    logic        limit_hit;
    logic [127:0] pat, msk;
    pat = {pat_hi, pat_lo};
    msk = {msk_hi, msk_lo};
    len = active_len();
    for (int i = MAX_PATTERN_BYTES - 1; i > 0; i--) recent_bytes[i] = recent_bytes[i-1];
    recent_bytes[0] = b;
    if (file_count != {OFFSET_BITS{1'b1}}) file_count++;
    limit_hit = !limit_raw[31] && ({1'b0, found_count} >= limit_raw);
    if (file_count >= OFFSET_BITS'(len) && !limit_hit) begin
      hit = 1'b1;
      for (int i = 0; i < len; i++)
        if ((recent_bytes[len-1-i] & msk[8*i +: 8]) != pat[8*i +: 8]) hit = 1'b0;
      if (hit) begin
        expected_offsets.push_back(file_count - OFFSET_BITS'(len));
        if (found_count != '1) found_count++;
      end
    end
    if (eof) begin
      foreach (recent_bytes[i]) recent_bytes[i] = 8'd0;
      file_count = '0;
    end
  endtask

  // result check and input prediction, both on the rising edge
  always @(posedge clk) begin
    in_accepted <= !rst && in_valid && !in_stall;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_offsets.size() == 0) begin
          note_failure($sformatf("offset %0d reported with none expected", match_offset));
        end else begin
          if (match_offset !== expected_offsets[0])
            note_failure($sformatf("offset expected %0d, got %0d",
                                   expected_offsets[0], match_offset));
          void'(expected_offsets.pop_front());
          offsets_checked++;
        end
      end
      if (in_valid && !in_stall) begin
        scan_byte(data_byte, end_of_file);
        bytes_taken++;
        if (end_of_file) files_closed++;
      end
    end
  end

  // byte driver: a beat is held until taken, gaps at random
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_accepted) begin
      if (pending_bytes.size() != 0 && (no_idle || $urandom_range(0, 99) >= 24)) begin
        next_beat = pending_bytes.pop_front();
        in_valid    <= 1'b1;
        data_byte   <= next_beat.data;
        end_of_file <= next_beat.eof;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver: random stalls, plus long hold-offs on request
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      out_stall    <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end else begin
      out_stall <= !no_idle && ($urandom_range(0, 99) < 24);
    end
  end

  // register write: setup cycle, then access cycle
  task automatic apb_write(input logic [RIDX_BITS-1:0] idx, input logic [63:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, {REG_LSB{1'b0}}};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_PATTERN_LOW:  pat_lo    = value;
      REG_PATTERN_HIGH: pat_hi    = value;
      REG_MASK_LOW:     msk_lo    = value;
      REG_MASK_HIGH:    msk_hi    = value;
      REG_PATTERN_LEN:  len_raw   = value[4:0];
      REG_MATCH_LIMIT:  limit_raw = value[31:0];
      default: ;
    endcase
  endtask

  // load all six registers; unused upper bits carry junk
  task automatic program_search(input logic [63:0] pl, input logic [63:0] ph,
                                input logic [63:0] ml, input logic [63:0] mh,
                                input logic [4:0] len, input logic [31:0] lim);
    apb_write(REG_PATTERN_LOW, pl);
    apb_write(REG_PATTERN_HIGH, ph);
    apb_write(REG_MASK_LOW, ml);
    apb_write(REG_MASK_HIGH, mh);
    apb_write(REG_PATTERN_LEN, {$urandom, 27'($urandom), len});
    apb_write(REG_MATCH_LIMIT, {$urandom, lim});
    settings_loaded++;
  endtask

  task automatic add_byte(input logic [7:0] d, input logic eof);
    byte_beat_t beat;
    beat.data = d;
    beat.eof  = eof;
    pending_bytes.push_back(beat);
  endtask

  // wait until every byte is taken and every offset has come back
  task automatic drain_pipeline();
    int guard;
    guard = 0;
    while (pending_bytes.size() != 0 || in_valid) @(posedge clk);
    while (expected_offsets.size() != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    if (expected_offsets.size() != 0) begin
      note_failure($sformatf("%0d offsets never reported, first %0d",
                             expected_offsets.size(), expected_offsets[0]));
      mismatch_count += expected_offsets.size() - 1;
      expected_offsets.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_mask_byte();
    case ($urandom_range(0, 7))
      4:       return 8'hF0;
      5:       return 8'h0F;
      6:       return 8'h00;
      7:       return 8'($urandom);
      default: return 8'hFF;
    endcase
  endfunction

  task automatic load_random_settings();
    logic [127:0] p, m;
    logic [4:0]   len;
    logic [31:0]  lim;
    for (int i = 0; i < MAX_PATTERN_BYTES; i++) m[8*i +: 8] = pick_mask_byte();
    p = {$urandom, $urandom, $urandom, $urandom};
    // mostly reachable patterns; now and then bits outside the mask
    if ($urandom_range(0, 7) != 0) p = p & m;
    if ($urandom_range(0, 9) == 0) begin
      p = '1;
      m = '1;
    end
    case ($urandom_range(0, 5))
      0:       len = 5'($urandom_range(1, 4));
      1:       len = 5'($urandom_range(5, 16));
      2:       len = 5'd0;
      3:       len = 5'($urandom_range(17, 31));
      4:       len = 5'd16;
      default: len = 5'd1;
    endcase
    case ($urandom_range(0, 7))
      4:       lim = 32'h7FFF_FFFF;
      5:       lim = 32'(found_count) + 32'($urandom_range(0, 15));
      6:       lim = 32'd0;
      7:       lim = 32'h8000_0000 | $urandom;
      default: lim = 32'hFFFF_FFFF;
    endcase
    program_search(p[63:0], p[127:64], m[63:0], m[127:64], len, lim);
  endtask

  // planted occurrences with random wildcard content, some broken, plus noise
  task automatic fill_random(input int n_bytes);
    int          len, k, broken;
    logic [7:0]  v, p, m;
    len = active_len();
    k = 0;
    while (k < n_bytes) begin
      if ($urandom_range(0, 99) < 55) begin
        broken = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len - 1) : -1;
        for (int i = 0; i < len; i++) begin
          p = i < 8 ? pat_lo[8*i +: 8] : pat_hi[8*(i-8) +: 8];
          m = i < 8 ? msk_lo[8*i +: 8] : msk_hi[8*(i-8) +: 8];
          v = (p & m) | (8'($urandom) & ~m);
          if (i == broken) v = v ^ (8'd1 << $urandom_range(0, 7));
          add_byte(v, $urandom_range(0, 59) == 0);
        end
        k += len;
      end else begin
        add_byte(8'($urandom), $urandom_range(0, 59) == 0);
        k++;
      end
    end
  endtask

  // main sequence
  initial begin
    pat_lo = '0; pat_hi = '0; msk_lo = '0; msk_hi = '0;
    len_raw = 5'd1;
    limit_raw = 32'hFFFF_FFFF;
    foreach (recent_bytes[i]) recent_bytes[i] = 8'd0;
    file_count  = '0;
    found_count = '0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // settings after reset: every byte matches
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b1);
    add_byte(8'h5A, 1'b1);
    drain_pipeline();

    // three-byte pattern with nibble wildcards
    program_search(64'h0000_0000_000C_50AA, '0, 64'h0000_0000_000F_F0FF, '0, 5'd3,
                   32'hFFFF_FFFF);
    add_byte(8'hAA, 1'b0); add_byte(8'h57, 1'b0); add_byte(8'h3C, 1'b0);
    add_byte(8'hAA, 1'b0); add_byte(8'h5F, 1'b0); add_byte(8'hFC, 1'b0);
    add_byte(8'hAA, 1'b0); add_byte(8'h40, 1'b0); add_byte(8'h0C, 1'b0);
    // file ends before the pattern completes
    add_byte(8'hAA, 1'b0); add_byte(8'h51, 1'b1);
    // match finished by the end-of-file byte itself
    add_byte(8'hEC, 1'b0); add_byte(8'hAA, 1'b0); add_byte(8'h5E, 1'b0);
    add_byte(8'hEC, 1'b1);
    drain_pipeline();

    // overlapping matches
    program_search(64'h0000_0000_0000_AAAA, '0, 64'h0000_0000_0000_FFFF, '0, 5'd2,
                   32'hFFFF_FFFF);
    add_byte(8'hAA, 1'b0); add_byte(8'hAA, 1'b0); add_byte(8'hAA, 1'b1);
    drain_pipeline();

    // pattern bit outside the mask never matches
    program_search(64'h0F, '0, 64'hF0, '0, 5'd1, 32'hFFFF_FFFF);
    add_byte(8'hFF, 1'b0); add_byte(8'h0F, 1'b1);
    drain_pipeline();

    // random phases
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      no_idle = (ph == 6);
      if (ph == 3) begin
        // every byte matches while the receiver holds off
        program_search('0, '0, '0, '0, 5'd1, 32'hFFFF_FFFF);
        hold_requests++;
      end else begin
        load_random_settings();
      end
      fill_random(PHASE_BYTES);
      drain_pipeline();
    end
    no_idle = 1'b0;

    $display("bytes taken: %0d in %0d closed files, offsets checked: %0d",
             bytes_taken, files_closed, offsets_checked);
    $display("search settings loaded: %0d, final match count: %0d",
             settings_loaded, found_count);
    if (mismatch_count == 0) begin
      $display("[masked_byte_pattern_search_core] OK");
    end else begin
      $display("[masked_byte_pattern_search_core] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("[masked_byte_pattern_search_core] ERROR");
    $finish;
  end

endmodule
